// File: rtl/dpf_pkg.sv
package dpf_pkg;

	localparam int PROCESSES  = 4;
	localparam int PAGES      = 16;
	localparam int FRAMES     = 8;
	localparam int LINE_BYTES = 16;
	localparam int DISK_SLOTS = 32;

	localparam int PROC_W  = 2;
	localparam int PAGE_W  = 4;
	localparam int OFF_W   = 4;
	localparam int FRAME_W = 3;
	localparam int PA_W    = 7;
	localparam int BYTE_W  = 8;

	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_FAULT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [PROC_W-1:0] process;
		logic              op;
		logic [PAGE_W-1:0] page;
		logic [OFF_W-1:0]  offset;
	} dpf_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FRAME_W-1:0] allocated_frame;
		logic               evicted;
		logic [FRAME_W-1:0] evicted_frame;
		logic               wrote_back;
		logic [PA_W-1:0]    phys_addr;
		logic [BYTE_W-1:0]  read_data;
		logic               read_valid;
	} dpf_rsp_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;      // latch request, compute lookup
		logic evict;     // pick victim, update victim entry
		logic wb_step;   // one write-back byte
		logic alloc;     // commit new mapping
		logic rl_step;   // one reload byte
		logic acc_rd;    // issue RAM access read
		logic finish;    // do access, drive result
		logic drop;      // disk slots exhausted result
	} dpf_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic hit;
		logic full;
		logic free_found;
		logic need_wb;
		logic need_rl;
		logic last_byte;
	} dpf_sts_t;

endpackage

// File: rtl/demand_paging_fifo_replacement_unit.sv
// Demand-paged memory with first-in first-out frame replacement.
// Request channel: drive req and raise start; the request is taken at a
// rising edge where start is high and busy is low. Busy stays high until
// the result has been issued.
// Result channel: rsp carries one result per request, marked by a one-cycle
// done strobe. The receiver cannot hold results off.
// Steps: a hit passes the lookup, the access read and the finish before done
// rises; a request dropped because the disk slots ran out passes the lookup
// and the drop. A fault adds the frame allocation, an eviction when no frame
// is free, a byte-at-a-time write-back of a modified victim to disk and a
// byte-at-a-time reload of the page from its disk slot when it has one. One
// request is worked on at a time; the next one can be taken at the edge that
// ends the done cycle.
// Reset: arst_n clears the page table flags, the frame list and the slot
// counter at once; then a clearing pass zeroes RAM and disk, one byte of
// each per cycle, over every address of both. Busy is high during the pass.
module demand_paging_fifo_replacement_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dpf_pkg::dpf_req_t req,
	output logic              done,
	output dpf_pkg::dpf_rsp_t rsp
);
	import dpf_pkg::*;

	dpf_cmd_t cmd;
	dpf_sts_t sts;
	logic     clr_done;

	dpf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .clr_done(clr_done),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	dpf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.clr_done(clr_done), .rsp(rsp), .rsp_valid(done)
	);
endmodule

// File: rtl/dpf_ram.sv
module dpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/dpf_ctrl.sv
module dpf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              clr_done,
	input  dpf_pkg::dpf_sts_t sts,
	output dpf_pkg::dpf_cmd_t cmd,
	output logic              busy
);
	import dpf_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_LOOK  = 10'b0000000100,
		S_EVICT = 10'b0000001000,
		S_WB    = 10'b0000010000,
		S_ALLOC = 10'b0000100000,
		S_RL    = 10'b0001000000,
		S_ACC   = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_DROP  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_CLEAR: begin
				if (clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.hit) state_d = S_ACC;
				else if (sts.full) state_d = S_DROP;
				else if (sts.free_found) state_d = S_ALLOC;
				else state_d = S_EVICT;
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_d = sts.need_wb ? S_WB : S_ALLOC;
			end
			S_WB: begin
				cmd.wb_step = 1'b1;
				if (sts.last_byte) state_d = S_ALLOC;
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d = sts.need_rl ? S_RL : S_ACC;
			end
			S_RL: begin
				cmd.rl_step = 1'b1;
				if (sts.last_byte) state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc_rd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			S_DROP: begin
				cmd.drop = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

// File: rtl/dpf_dp.sv
module dpf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  dpf_pkg::dpf_req_t req,
	input  dpf_pkg::dpf_cmd_t cmd,
	output dpf_pkg::dpf_sts_t sts,
	output logic              clr_done,
	output dpf_pkg::dpf_rsp_t rsp,
	output logic              rsp_valid
);
	import dpf_pkg::*;

	localparam int ENTRIES = PROCESSES * PAGES;
	localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PGW = $clog2(PAGES);
	localparam int PRW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int FW  = $clog2(FRAMES);
	localparam int OW  = $clog2(LINE_BYTES);
	localparam int SW  = $clog2(DISK_SLOTS);
	localparam int RAW = FW + OW;
	localparam int DAW = SW + OW;
	localparam int ENT_W = FW + SW;
	localparam int RAM_DEPTH  = FRAMES * LINE_BYTES;
	localparam int DISK_DEPTH = DISK_SLOTS * LINE_BYTES;
	localparam int CW  = (DAW > RAW) ? DAW : RAW;

	// Page table flags live in flip-flops; frame and slot fields sit in a RAM.
	logic [ENTRIES-1:0] present_q, modified_q, has_slot_q;
	logic [FRAMES-1:0]  taken_q;
	logic [EW-1:0]      owner_q [FRAMES];
	logic [FW-1:0]      fifo_q [FRAMES];
	logic [FW-1:0]      head_q, tail_q;
	logic [SW:0]        next_slot_q;

	logic [EW-1:0]     e_q;
	logic              wr_q;
	logic [OW-1:0]     off_q;
	logic [FW-1:0]     frame_q;
	logic              ev_q, wb_q, fault_q;
	logic              free_found_q;
	logic [SW-1:0]     wb_slot_q, rl_slot_q;
	logic [OW:0]       cnt_q;
	logic              pend_q;
	logic [OW-1:0]     pend_off_q;
	logic              clearing_q;
	logic [CW:0]       clr_q;
	logic              look_q;
	logic              byp_q;
	logic [BYTE_W-1:0] byp_data_q;

	// Index wrap of the request fields.
	logic [PRW-1:0] proc_w;
	logic [PGW-1:0] page_w;
	logic [OW-1:0]  off_w;
	assign proc_w = PRW'(32'(req.process) % PROCESSES);
	assign page_w = PGW'(32'(req.page) % PAGES);
	assign off_w  = OW'(32'(req.offset) % LINE_BYTES);

	// Lowest free frame.
	logic [FW-1:0] free_idx;
	logic          free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (!taken_q[i]) begin
				free_idx = FW'(i);
				free_any = 1'b1;
			end
		end
	end

	logic [FW-1:0] victim;
	logic [EW-1:0] vown;
	assign victim = fifo_q[head_q];
	assign vown   = owner_q[victim];

	// Page table frame and slot fields.
	logic             ent_we;
	logic [EW-1:0]    ent_ra;
	logic [ENT_W-1:0] ent_wd, ent_rd;
	logic [FW-1:0]    ent_frame, acc_frame;
	logic [SW-1:0]    ent_slot;
	assign ent_frame = ent_rd[ENT_W-1:SW];
	assign ent_slot  = ent_rd[SW-1:0];
	// The victim's entry is fetched in the lookup cycle when a fault must evict;
	// otherwise the requesting entry is read.
	assign ent_ra = (look_q && !present_q[e_q] && !free_found_q) ? vown : e_q;
	assign ent_we = cmd.alloc;
	assign ent_wd = {frame_q, has_slot_q[e_q] ? ent_slot : next_slot_q[SW-1:0]};
	assign acc_frame = fault_q ? frame_q : ent_frame;

	dpf_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entry (
		.clk(clk), .we(ent_we), .waddr(e_q), .wdata(ent_wd),
		.raddr(ent_ra), .rdata(ent_rd)
	);

	logic vlive;
	assign vlive = present_q[vown] && (ent_frame == victim);

	assign sts.hit        = present_q[e_q];
	assign sts.full       = !has_slot_q[e_q] && (next_slot_q >= (SW+1)'(DISK_SLOTS));
	assign sts.free_found = free_found_q;
	assign sts.need_wb    = vlive && modified_q[vown];
	assign sts.need_rl    = has_slot_q[e_q];
	assign sts.last_byte  = (cnt_q[OW-1:0] == OW'(LINE_BYTES - 1));

	// Memories. Byte copies are written in the cycle after their read address.
	logic              ram_we, disk_we;
	logic [RAW-1:0]    ram_wa, ram_ra;
	logic [DAW-1:0]    disk_wa, disk_ra;
	logic [BYTE_W-1:0] ram_wd, disk_wd, ram_rd, disk_rd;
	logic              pend_wb_q, pend_rl_q;
	logic [SW-1:0]     pend_slot_q;
	logic [FW-1:0]     pend_frame_q;

	always_comb begin
		ram_we  = 1'b0;
		ram_wa  = '0;
		ram_wd  = '0;
		disk_we = 1'b0;
		disk_wa = '0;
		disk_wd = '0;
		ram_ra  = {frame_q, cnt_q[OW-1:0]};
		disk_ra = {rl_slot_q, cnt_q[OW-1:0]};
		if (cmd.wb_step) begin
			ram_ra = {frame_q, cnt_q[OW-1:0]};
		end
		if (cmd.acc_rd) begin
			ram_ra = {acc_frame, off_q};
		end
		if (clearing_q) begin
			ram_we  = (clr_q < (CW+1)'(RAM_DEPTH));
			ram_wa  = clr_q[RAW-1:0];
			disk_we = (clr_q < (CW+1)'(DISK_DEPTH));
			disk_wa = clr_q[DAW-1:0];
		end else begin
			if (pend_q && pend_wb_q) begin
				disk_we = 1'b1;
				disk_wa = {pend_slot_q, pend_off_q};
				disk_wd = ram_rd;
			end
			if (pend_q && pend_rl_q) begin
				ram_we = 1'b1;
				ram_wa = {pend_frame_q, pend_off_q};
				ram_wd = disk_rd;
			end
			if (cmd.finish && wr_q) begin
				ram_we = 1'b1;
				ram_wa = {acc_frame, off_q};
				ram_wd = BYTE_W'(1);
			end
		end
	end

	dpf_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	dpf_ram #(.WIDTH(BYTE_W), .DEPTH(DISK_DEPTH)) u_disk (
		.clk(clk), .we(disk_we), .waddr(disk_wa), .wdata(disk_wd),
		.raddr(disk_ra), .rdata(disk_rd)
	);

	assign clr_done = clearing_q && (clr_q == (CW+1)'(DISK_DEPTH > RAM_DEPTH ?
		DISK_DEPTH - 1 : RAM_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			modified_q  <= '0;
			has_slot_q  <= '0;
			taken_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			next_slot_q <= '0;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid   <= 1'b0;
			cnt_q       <= '0;
			look_q      <= 1'b0;
		end else begin
			rsp_valid <= cmd.finish || cmd.drop;
			pend_q    <= cmd.wb_step || cmd.rl_step;
			look_q    <= cmd.load;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_done) clearing_q <= 1'b0;
			end
			if (cmd.load) begin
				e_q          <= EW'(32'(proc_w) * PAGES + 32'(page_w));
				wr_q         <= req.op;
				off_q        <= off_w;
				free_found_q <= free_any;
				ev_q         <= 1'b0;
				wb_q         <= 1'b0;
				fault_q      <= 1'b0;
				frame_q      <= free_idx;
				cnt_q        <= '0;
			end
			if (cmd.evict) begin
				frame_q   <= victim;
				ev_q      <= 1'b1;
				head_q    <= FW'((32'(head_q) + 1) % FRAMES);
				wb_slot_q <= ent_slot;
				wb_q      <= vlive && modified_q[vown];
				if (vlive) present_q[vown] <= 1'b0;
			end
			if (cmd.wb_step || cmd.rl_step) begin
				pend_wb_q    <= cmd.wb_step;
				pend_rl_q    <= cmd.rl_step;
				pend_off_q   <= cnt_q[OW-1:0];
				pend_slot_q  <= wb_slot_q;
				pend_frame_q <= frame_q;
				cnt_q <= sts.last_byte ? '0 : cnt_q + 1'b1;
			end
			if (cmd.alloc) begin
				fault_q <= 1'b1;
				if (!ev_q) taken_q[frame_q] <= 1'b1;
				if (!has_slot_q[e_q]) begin
					has_slot_q[e_q] <= 1'b1;
					next_slot_q     <= next_slot_q + 1'b1;
				end
				rl_slot_q        <= ent_slot;
				present_q[e_q]   <= 1'b1;
				modified_q[e_q]  <= 1'b0;
				owner_q[frame_q] <= e_q;
				fifo_q[tail_q]   <= frame_q;
				tail_q <= FW'((32'(tail_q) + 1) % FRAMES);
			end
			if (cmd.acc_rd) begin
				// The last reloaded byte is written while the access read is issued.
				byp_q      <= ram_we && (ram_wa == ram_ra);
				byp_data_q <= ram_wd;
			end
			if (cmd.finish) begin
				rsp.status          <= fault_q ? ST_FAULT : ST_HIT;
				rsp.allocated_frame <= fault_q ? FRAME_W'(frame_q) : '0;
				rsp.evicted         <= ev_q;
				rsp.evicted_frame   <= ev_q ? FRAME_W'(frame_q) : '0;
				rsp.wrote_back      <= wb_q;
				rsp.phys_addr <= PA_W'({acc_frame, off_q});
				rsp.read_data <= (wr_q == OP_WRITE) ? '0 : (byp_q ? byp_data_q : ram_rd);
				rsp.read_valid <= (wr_q == OP_READ);
				if (wr_q == OP_WRITE) modified_q[e_q] <= 1'b1;
			end
			if (cmd.drop) begin
				rsp <= dpf_rsp_t'{status: ST_FULL, default: '0};
			end
		end
	end
endmodule

// File: rtl/dpf_checker.sv
module dpf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input dpf_pkg::dpf_rsp_t rsp
);
	import dpf_pkg::*;

	// An accepted request makes the block busy.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");

	// A result comes only after the block has been busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without request");

	// A result frees the block.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy after result");

	// A dropped request reports nothing else.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> !rsp.read_valid && !rsp.evicted)
		else $error("dropped request with data");
endmodule

bind demand_paging_fifo_replacement_unit dpf_checker u_dpf_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .rsp(rsp)
);

// File: test/tb.sv
module tb;
	import dpf_pkg::*;

	localparam int ENTRY_CNT  = 64;
	localparam int FRAME_CNT  = 8;
	localparam int LINE_LEN   = 16;
	localparam int SLOT_CNT   = 32;
	localparam int POOL_SIZE  = 24;
	localparam int STALL_LIMIT = 4000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	dpf_req_t req;
	logic     done;
	dpf_rsp_t rsp;

	demand_paging_fifo_replacement_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// Shadow copy of the paging state.
	logic       pt_present [ENTRY_CNT];
	logic       pt_dirty [ENTRY_CNT];
	logic [2:0] pt_frame [ENTRY_CNT];
	logic       pt_has_slot [ENTRY_CNT];
	logic [4:0] pt_slot [ENTRY_CNT];
	logic       frame_held [FRAME_CNT];
	logic [5:0] frame_owner [FRAME_CNT];
	logic [2:0] load_order [FRAME_CNT];
	logic [2:0] order_head;
	logic [2:0] order_tail;
	logic [7:0] ram_mem [FRAME_CNT*LINE_LEN];
	logic [7:0] disk_mem [SLOT_CNT*LINE_LEN];
	int         slots_given;

	dpf_rsp_t   pending_rsp [$];
	int         error_count;
	int         stall_cycles;
	bit         calm;
	logic [5:0] pool [POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic dpf_rsp_t predict_access(dpf_req_t r);
		dpf_rsp_t   res;
		logic [5:0] e;
		logic [5:0] owner;
		logic [2:0] fr;
		logic [2:0] victim;
		bit         found;
		res = '0;
		e = {r.process, r.page};
		if (!pt_present[e]) begin
			if (!pt_has_slot[e] && slots_given >= SLOT_CNT) begin
				res.status = ST_FULL;
				return res;
			end
			found = 0;
			fr = '0;
			for (int i = 0; i < FRAME_CNT; i++)
				if (!found && !frame_held[i]) begin
					fr = 3'(i);
					found = 1;
				end
			if (found) begin
				frame_held[fr] = 1'b1;
			end else begin
				victim = load_order[order_head];
				owner = frame_owner[victim];
				order_head = order_head + 3'd1;
				fr = victim;
				res.evicted = 1'b1;
				res.evicted_frame = victim;
				if (pt_present[owner] && pt_frame[owner] == victim) begin
					if (pt_dirty[owner]) begin
						for (int b = 0; b < LINE_LEN; b++)
							disk_mem[pt_slot[owner]*LINE_LEN+b] = ram_mem[victim*LINE_LEN+b];
						res.wrote_back = 1'b1;
					end
					pt_present[owner] = 1'b0;
				end
			end
			if (!pt_has_slot[e]) begin
				pt_slot[e] = slots_given[4:0];
				pt_has_slot[e] = 1'b1;
				slots_given++;
			end else begin
				for (int b = 0; b < LINE_LEN; b++)
					ram_mem[fr*LINE_LEN+b] = disk_mem[pt_slot[e]*LINE_LEN+b];
			end
			pt_frame[e] = fr;
			pt_present[e] = 1'b1;
			pt_dirty[e] = 1'b0;
			frame_owner[fr] = e;
			load_order[order_tail] = fr;
			order_tail = order_tail + 3'd1;
			res.status = ST_FAULT;
			res.allocated_frame = fr;
		end
		res.phys_addr = {pt_frame[e], r.offset};
		if (r.op == OP_WRITE) begin
			ram_mem[res.phys_addr] = 8'd1;
			pt_dirty[e] = 1'b1;
		end else begin
			res.read_data = ram_mem[res.phys_addr];
			res.read_valid = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	// Result checker and watchdog.
	always @(posedge clk) begin
		dpf_rsp_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles > STALL_LIMIT) begin
				$display("demand_paging_fifo_replacement_unit test failed");
				$finish;
			end
		end
		if (done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status != want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.allocated_frame != want.allocated_frame)
					report_mismatch("allocated_frame", int'(rsp.allocated_frame),
						int'(want.allocated_frame));
				if (rsp.evicted != want.evicted)
					report_mismatch("evicted", int'(rsp.evicted), int'(want.evicted));
				if (rsp.evicted_frame != want.evicted_frame)
					report_mismatch("evicted_frame", int'(rsp.evicted_frame),
						int'(want.evicted_frame));
				if (rsp.wrote_back != want.wrote_back)
					report_mismatch("wrote_back", int'(rsp.wrote_back),
						int'(want.wrote_back));
				if (rsp.phys_addr != want.phys_addr)
					report_mismatch("phys_addr", int'(rsp.phys_addr),
						int'(want.phys_addr));
				if (rsp.read_data != want.read_data)
					report_mismatch("read_data", int'(rsp.read_data),
						int'(want.read_data));
				if (rsp.read_valid != want.read_valid)
					report_mismatch("read_valid", int'(rsp.read_valid),
						int'(want.read_valid));
			end
		end
	end

	// Drives one request and waits until the block takes it.
	task automatic send_access(logic [5:0] e, logic op, logic [3:0] off);
		dpf_req_t r;
		r.process = e[5:4];
		r.page = e[3:0];
		r.op = op;
		r.offset = off;
		@(negedge clk);
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_rsp.insert(pending_rsp.size(), predict_access(r));
		if (!calm && $urandom_range(99) < 29) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
	endtask

	// First touches, write then read back, eviction of a dirty frame and reload.
	task automatic test_directed();
		send_access(pool[0], OP_READ, 4'd0);
		send_access(pool[0], OP_WRITE, 4'd15);
		send_access(pool[0], OP_READ, 4'd15);
		send_access(pool[1], OP_WRITE, 4'd15);
		send_access(pool[1], OP_READ, 4'd0);
		for (int i = 2; i < 9; i++)
			send_access(pool[i], OP_READ, i[3:0]);
		send_access(pool[0], OP_READ, 4'd15);
		send_access(pool[0], OP_READ, 4'd7);
		send_access(pool[1], OP_READ, 4'd15);
		drain_results();
	endtask

	task automatic test_working_set(int count);
		for (int n = 0; n < count; n++) begin
			calm = (n >= count / 3 && n < count / 2);
			send_access(pool[$urandom_range(POOL_SIZE - 1)], 1'($urandom_range(1)),
				4'($urandom_range(15)));
		end
		calm = 0;
		drain_results();
	endtask

	// Touches every entry so the disk slots run out.
	task automatic test_slot_exhaustion();
		for (int e = 0; e < ENTRY_CNT; e++)
			send_access(e[5:0], e[0], e[3:0]);
		drain_results();
	endtask

	task automatic test_full_range(int count);
		for (int n = 0; n < count; n++)
			send_access(6'($urandom_range(ENTRY_CNT - 1)), 1'($urandom_range(1)),
				4'($urandom_range(15)));
		drain_results();
	endtask

	initial begin
		bit dup;
		logic [5:0] cand;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		error_count = 0;
		stall_cycles = 0;
		calm = 0;
		for (int i = 0; i < ENTRY_CNT; i++) begin
			pt_present[i] = 0;
			pt_dirty[i] = 0;
			pt_has_slot[i] = 0;
			pt_frame[i] = '0;
			pt_slot[i] = '0;
		end
		for (int i = 0; i < FRAME_CNT; i++) begin
			frame_held[i] = 0;
			frame_owner[i] = '0;
			load_order[i] = '0;
		end
		foreach (ram_mem[i]) ram_mem[i] = '0;
		foreach (disk_mem[i]) disk_mem[i] = '0;
		order_head = '0;
		order_tail = '0;
		slots_given = 0;
		pool[0] = 6'd0;
		pool[1] = 6'd63;
		for (int i = 2; i < POOL_SIZE; i++) begin
			do begin
				cand = 6'($urandom_range(ENTRY_CNT - 1));
				dup = 0;
				for (int j = 0; j < i; j++)
					if (pool[j] == cand) dup = 1;
			end while (dup);
			pool[i] = cand;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_working_set(1000);
		test_slot_exhaustion();
		test_full_range(820);

		repeat (60) @(posedge clk);
		if (error_count == 0 && pending_rsp.size() == 0)
			$display("demand_paging_fifo_replacement_unit test passed");
		else
			$display("demand_paging_fifo_replacement_unit test failed");
		$finish;
	end
endmodule

// File: filelist.f
rtl/dpf_pkg.sv
rtl/dpf_ram.sv
rtl/dpf_ctrl.sv
rtl/dpf_dp.sv
rtl/demand_paging_fifo_replacement_unit.sv
rtl/dpf_checker.sv
test/tb.sv
